@@ rtl/lbci_pkg.sv @@
// Shared constants and types for the LED blink-code status indicator.
package lbci_pkg;

   localparam int unsigned WORD_WIDTH  = 16;
   localparam int unsigned PHASE_WIDTH = 4;
   localparam int unsigned TOGGLE_WIDTH = 4;
   localparam int unsigned MASK_COUNT  = 5;
   localparam int unsigned SLOT_COUNT_DEFAULT = 5;
   localparam int unsigned INDEX_WIDTH = 3;
   localparam int unsigned SLOT_WIDTH  = 3;

   localparam logic [WORD_WIDTH-1:0] BLINK_HALF_RESET = 16'd150;
   localparam logic [WORD_WIDTH-1:0] CYCLE_RESET      = 16'd3000;
   localparam logic [WORD_WIDTH-1:0] IDLE_RESET       = 16'd1500;

   typedef enum logic [INDEX_WIDTH-1:0] {
      REG_MASK_SLOT0  = 3'd0,
      REG_MASK_SLOT1  = 3'd1,
      REG_MASK_SLOT2  = 3'd2,
      REG_MASK_SLOT3  = 3'd3,
      REG_MASK_SLOT4  = 3'd4,
      REG_BLINK_HALF  = 3'd5,
      REG_CYCLE       = 3'd6,
      REG_IDLE        = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [MASK_COUNT-1:0][WORD_WIDTH-1:0] mask;
      logic [WORD_WIDTH-1:0]                 blink_half;
      logic [WORD_WIDTH-1:0]                 cycle;
      logic [WORD_WIDTH-1:0]                 idle;
   } cfg_type;

   function automatic logic [WORD_WIDTH-1:0] mask_reset(input int unsigned slot);
      mask_reset = WORD_WIDTH'(1) << slot;
   endfunction

endpackage

@@ rtl/lbci_regs.sv @@
// Configuration register file of the LED blink-code status indicator.
module lbci_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [lbci_pkg::INDEX_WIDTH-1:0]   csr_index,
   input  logic [lbci_pkg::WORD_WIDTH-1:0]    csr_write_data,
   output lbci_pkg::cfg_type                  cfg
);

   lbci_pkg::cfg_type cfg_ff;
   lbci_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (lbci_pkg::reg_index_type'(csr_index))
            lbci_pkg::REG_MASK_SLOT0: cfg_in.mask[0] = csr_write_data;
            lbci_pkg::REG_MASK_SLOT1: cfg_in.mask[1] = csr_write_data;
            lbci_pkg::REG_MASK_SLOT2: cfg_in.mask[2] = csr_write_data;
            lbci_pkg::REG_MASK_SLOT3: cfg_in.mask[3] = csr_write_data;
            lbci_pkg::REG_MASK_SLOT4: cfg_in.mask[4] = csr_write_data;
            lbci_pkg::REG_BLINK_HALF: cfg_in.blink_half = csr_write_data;
            lbci_pkg::REG_CYCLE:      cfg_in.cycle = csr_write_data;
            lbci_pkg::REG_IDLE:       cfg_in.idle = csr_write_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lbci_pkg::MASK_COUNT; i++) begin
            cfg_ff.mask[i] <= lbci_pkg::mask_reset(i);
         end
         cfg_ff.blink_half <= lbci_pkg::BLINK_HALF_RESET;
         cfg_ff.cycle      <= lbci_pkg::CYCLE_RESET;
         cfg_ff.idle       <= lbci_pkg::IDLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/led_blink_code_status_indicator.sv @@
// Top level of the LED blink-code status indicator: request register, tick update, response register.
//
//   Port group  Direction  Contents
//   req_        in         one tick with its status word, valid/ready
//   rsp_        out        LED level and slot phase after the tick, valid/ready
//   csr_        in         register write: enable, index, data
//
// Each request is held in the request register and then moves to the response register; one
// request is taken per cycle while the response is not stalled. The timer, phase, toggle count
// and LED level update when a request moves from the request register to the response register.
// A stalled response holds both stages. Synchronous reset clears the valid flags, timer, phase,
// toggle count and LED level and restores the register defaults, but not the data registers.
module led_blink_code_status_indicator #(
   parameter int unsigned SLOT_COUNT = lbci_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lbci_pkg::WORD_WIDTH-1:0]      req_status_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_led_on,
   output logic [lbci_pkg::PHASE_WIDTH-1:0]     rsp_slot_phase,
   input  logic                                 csr_write_enable,
   input  logic [lbci_pkg::INDEX_WIDTH-1:0]     csr_index,
   input  logic [lbci_pkg::WORD_WIDTH-1:0]      csr_write_data
);

   localparam logic [lbci_pkg::PHASE_WIDTH-1:0] PHASE_LIMIT =
      lbci_pkg::PHASE_WIDTH'(2 * SLOT_COUNT);

   lbci_pkg::cfg_type cfg;

   lbci_regs u_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   logic                                  req_valid_ff;
   logic [lbci_pkg::WORD_WIDTH-1:0]       status_ff;
   logic                                  rsp_valid_ff;
   logic                                  rsp_led_ff;
   logic [lbci_pkg::PHASE_WIDTH-1:0]      rsp_phase_ff;

   logic [lbci_pkg::PHASE_WIDTH-1:0]      phase_ff, phase_in;
   logic [lbci_pkg::TOGGLE_WIDTH-1:0]     toggles_ff, toggles_in;
   logic [lbci_pkg::WORD_WIDTH-1:0]       ticks_ff, ticks_in;
   logic                                  led_ff, led_in;

   logic                                  advance;
   logic [lbci_pkg::SLOT_WIDTH-1:0]       slot;
   logic [lbci_pkg::SLOT_WIDTH-1:0]       slot_count;
   logic [lbci_pkg::WORD_WIDTH-1:0]       mask;
   logic                                  hit;
   logic [lbci_pkg::WORD_WIDTH-1:0]       reload;
   logic [lbci_pkg::TOGGLE_WIDTH-1:0]     toggles_dec;
   logic [lbci_pkg::WORD_WIDTH+3:0]       blink_time;
   logic signed [lbci_pkg::WORD_WIDTH+4:0] pause;
   logic [lbci_pkg::PHASE_WIDTH-1:0]      phase_next;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   assign slot       = phase_ff[lbci_pkg::PHASE_WIDTH-1:1];
   assign slot_count = slot + lbci_pkg::SLOT_WIDTH'(1);
   assign mask       = (slot < lbci_pkg::SLOT_WIDTH'(lbci_pkg::MASK_COUNT)) ?
                       cfg.mask[slot] : '0;
   assign hit        = (status_ff & mask) != '0;
   assign toggles_dec = toggles_ff - lbci_pkg::TOGGLE_WIDTH'(1);
   assign blink_time = {(lbci_pkg::WORD_WIDTH+3)'(slot_count) * 
                        (lbci_pkg::WORD_WIDTH+3)'(cfg.blink_half), 1'b0};
   assign pause      = $signed({5'b0, cfg.cycle}) - $signed({1'b0, blink_time});

   always_comb begin
      phase_in   = phase_ff;
      toggles_in = toggles_ff;
      led_in     = led_ff;
      ticks_in   = ticks_ff;
      phase_next = phase_ff;
      reload     = (status_ff != '0) ? cfg.blink_half : cfg.idle;
      if (ticks_ff <= lbci_pkg::WORD_WIDTH'(1)) begin
         if (!phase_ff[0]) begin
            if (hit) begin
               toggles_in = {slot_count, 1'b0};
               phase_next = phase_ff + lbci_pkg::PHASE_WIDTH'(1);
            end else begin
               phase_next = phase_ff + lbci_pkg::PHASE_WIDTH'(2);
            end
         end else if (hit) begin
            led_in     = !led_ff;
            toggles_in = toggles_dec;
            if (toggles_dec == '0) begin
               phase_next = phase_ff + lbci_pkg::PHASE_WIDTH'(1);
               if (pause < $signed((lbci_pkg::WORD_WIDTH+5)'(1))) begin
                  reload = lbci_pkg::WORD_WIDTH'(1);
               end else begin
                  reload = pause[lbci_pkg::WORD_WIDTH-1:0];
               end
            end
         end
         phase_in = (phase_next >= PHASE_LIMIT) ? '0 : phase_next;
         ticks_in = reload;
      end else begin
         ticks_in = ticks_ff - lbci_pkg::WORD_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         toggles_ff   <= '0;
         ticks_ff     <= '0;
         led_ff       <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            toggles_ff   <= toggles_in;
            ticks_ff     <= ticks_in;
            led_ff       <= led_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         status_ff <= req_status_word;
      end
      if (advance) begin
         rsp_led_ff   <= led_in;
         rsp_phase_ff <= phase_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_on     = rsp_led_ff;
   assign rsp_slot_phase = rsp_phase_ff;

endmodule

@@ tb/tb_led_blink_code_status_indicator.sv @@
// Self-checking testbench for the LED blink-code status indicator, driven by tick requests.
`timescale 1ns / 1ps

module tb_led_blink_code_status_indicator;

   localparam int unsigned SLOT_N      = lbci_pkg::SLOT_COUNT_DEFAULT;
   localparam int unsigned IDLE_PCT    = 34;
   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned PHASE_COUNT = 10;
   localparam int unsigned DIRECTED_N  = 23;

   typedef struct packed {
      logic                             led_on;
      logic [lbci_pkg::PHASE_WIDTH-1:0] slot_phase;
   } indication_type;

   typedef struct packed {
      logic [lbci_pkg::WORD_WIDTH-1:0] status;
      logic                            pinned;
      indication_type                  ind;
   } tick_row_type;

   // Rows marked pinned carry an expectation that can be read off the reset state directly.
   localparam tick_row_type DIRECTED [DIRECTED_N] = '{
      {16'h0001, 1'b1, 1'b0, 4'd1},
      {16'h0000, 1'b1, 1'b0, 4'd1},
      {16'h0001, 1'b0, 1'b0, 4'd0},
      {16'h0001, 1'b0, 1'b0, 4'd0},
      {16'h0000, 1'b0, 1'b0, 4'd0},
      {16'hFFFF, 1'b0, 1'b0, 4'd0},
      {16'hFFFF, 1'b0, 1'b0, 4'd0},
      {16'hFFFF, 1'b0, 1'b0, 4'd0},
      {16'hFFFF, 1'b0, 1'b0, 4'd0},
      {16'hFFFF, 1'b0, 1'b0, 4'd0},
      {16'hFFFF, 1'b0, 1'b0, 4'd0},
      {16'hFFFF, 1'b0, 1'b0, 4'd0},
      {16'h0008, 1'b0, 1'b0, 4'd0},
      {16'h0010, 1'b0, 1'b0, 4'd0},
      {16'h0008, 1'b0, 1'b0, 4'd0},
      {16'h0008, 1'b0, 1'b0, 4'd0},
      {16'h0008, 1'b0, 1'b0, 4'd0},
      {16'h0008, 1'b0, 1'b0, 4'd0},
      {16'h0008, 1'b0, 1'b0, 4'd0},
      {16'h0008, 1'b0, 1'b0, 4'd0},
      {16'h0008, 1'b0, 1'b0, 4'd0},
      {16'h0008, 1'b0, 1'b0, 4'd0},
      {16'h0000, 1'b0, 1'b0, 4'd0}
   };

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [lbci_pkg::WORD_WIDTH-1:0]   req_status_word;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic                              rsp_led_on;
   logic [lbci_pkg::PHASE_WIDTH-1:0]  rsp_slot_phase;
   logic                              csr_write_enable;
   logic [lbci_pkg::INDEX_WIDTH-1:0]  csr_index;
   logic [lbci_pkg::WORD_WIDTH-1:0]   csr_write_data;

   logic [lbci_pkg::WORD_WIDTH-1:0]   mdl_mask [lbci_pkg::MASK_COUNT];
   logic [lbci_pkg::WORD_WIDTH-1:0]   mdl_half;
   logic [lbci_pkg::WORD_WIDTH-1:0]   mdl_cycle;
   logic [lbci_pkg::WORD_WIDTH-1:0]   mdl_idle;
   logic [lbci_pkg::PHASE_WIDTH-1:0]  mdl_phase;
   logic [lbci_pkg::TOGGLE_WIDTH-1:0] mdl_toggles;
   logic [lbci_pkg::WORD_WIDTH-1:0]   mdl_ticks;
   logic                              mdl_led;

   indication_type pending_ind [$];
   logic           pin_use;
   indication_type pin_ind;
   logic           quiet;
   int unsigned    error_count;
   int unsigned    stall_cycles;

   led_blink_code_status_indicator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_status_word  (req_status_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_led_on       (rsp_led_on),
      .rsp_slot_phase   (rsp_slot_phase),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_status_word  = '0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      pin_use          = 1'b0;
      pin_ind          = '0;
      quiet            = 1'b0;
      error_count      = 0;
      stall_cycles     = 0;
      for (int i = 0; i < lbci_pkg::MASK_COUNT; i++) begin
         mdl_mask[lbci_pkg::SLOT_WIDTH'(i)] = lbci_pkg::mask_reset(i);
      end
      mdl_half    = lbci_pkg::BLINK_HALF_RESET;
      mdl_cycle   = lbci_pkg::CYCLE_RESET;
      mdl_idle    = lbci_pkg::IDLE_RESET;
      mdl_phase   = '0;
      mdl_toggles = '0;
      mdl_ticks   = '0;
      mdl_led     = 1'b0;
   end

   always #5 clock = ~clock;

   function automatic indication_type advance_tick(
      input logic [lbci_pkg::WORD_WIDTH-1:0] status);
      int unsigned                     slot;
      logic [lbci_pkg::WORD_WIDTH-1:0] mask;
      logic                            hit;
      int                              pause;
      logic [31:0]                     reload;
      indication_type                  ind;
      if (mdl_ticks <= lbci_pkg::WORD_WIDTH'(1)) begin
         reload = (status != '0) ? 32'(mdl_half) : 32'(mdl_idle);
         slot   = 32'(mdl_phase >> 1);
         mask   = (slot < lbci_pkg::MASK_COUNT) ?
                  mdl_mask[lbci_pkg::SLOT_WIDTH'(slot)] : '0;
         hit    = (status & mask) != '0;
         if (!mdl_phase[0]) begin
            if (hit) begin
               mdl_toggles = lbci_pkg::TOGGLE_WIDTH'(2 * (slot + 1));
               mdl_phase   = mdl_phase + lbci_pkg::PHASE_WIDTH'(1);
            end else begin
               mdl_phase = mdl_phase + lbci_pkg::PHASE_WIDTH'(2);
            end
         end else if (hit) begin
            mdl_led     = ~mdl_led;
            mdl_toggles = mdl_toggles - lbci_pkg::TOGGLE_WIDTH'(1);
            if (mdl_toggles == '0) begin
               pause = int'(mdl_cycle) - 2 * (int'(slot) + 1) * int'(mdl_half);
               if (pause < 1) begin
                  pause = 1;
               end
               reload    = 32'(pause);
               mdl_phase = mdl_phase + lbci_pkg::PHASE_WIDTH'(1);
            end
         end
         if (mdl_phase >= lbci_pkg::PHASE_WIDTH'(2 * SLOT_N)) begin
            mdl_phase = '0;
         end
         mdl_ticks = reload[lbci_pkg::WORD_WIDTH-1:0];
      end else begin
         mdl_ticks = mdl_ticks - lbci_pkg::WORD_WIDTH'(1);
      end
      ind.led_on     = mdl_led;
      ind.slot_phase = mdl_phase;
      return ind;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      indication_type predicted;
      indication_type oldest;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_ind.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               oldest = pending_ind.pop_front();
               if (rsp_led_on !== oldest.led_on) begin
                  $error("led_on expected %0d actual %0d", oldest.led_on, rsp_led_on);
                  error_count++;
               end
               if (rsp_slot_phase !== oldest.slot_phase) begin
                  $error("slot_phase expected %0d actual %0d",
                         oldest.slot_phase, rsp_slot_phase);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted = advance_tick(req_status_word);
            if (pin_use) begin
               predicted = pin_ind;
            end
            pending_ind.push_back(predicted);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic write_reg(input lbci_pkg::reg_index_type idx,
                            input logic [lbci_pkg::WORD_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         lbci_pkg::REG_MASK_SLOT0: mdl_mask[0] = data;
         lbci_pkg::REG_MASK_SLOT1: mdl_mask[1] = data;
         lbci_pkg::REG_MASK_SLOT2: mdl_mask[2] = data;
         lbci_pkg::REG_MASK_SLOT3: mdl_mask[3] = data;
         lbci_pkg::REG_MASK_SLOT4: mdl_mask[4] = data;
         lbci_pkg::REG_BLINK_HALF: mdl_half    = data;
         lbci_pkg::REG_CYCLE:      mdl_cycle   = data;
         lbci_pkg::REG_IDLE:       mdl_idle    = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_timing(input logic [lbci_pkg::WORD_WIDTH-1:0] half,
                               input logic [lbci_pkg::WORD_WIDTH-1:0] cycle,
                               input logic [lbci_pkg::WORD_WIDTH-1:0] idle);
      write_reg(lbci_pkg::REG_BLINK_HALF, half);
      write_reg(lbci_pkg::REG_CYCLE, cycle);
      write_reg(lbci_pkg::REG_IDLE, idle);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_ind.size() != 0);
      @(posedge clock);
   endtask

   task automatic send_tick(input logic [lbci_pkg::WORD_WIDTH-1:0] status,
                            input logic pinned,
                            input indication_type pinned_ind);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_status_word <= status;
      pin_use         <= pinned;
      pin_ind         <= pinned_ind;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [lbci_pkg::WORD_WIDTH-1:0] pick_status();
      int unsigned                     sel;
      logic [lbci_pkg::WORD_WIDTH-1:0] status;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         status = mdl_mask[lbci_pkg::SLOT_WIDTH'($urandom_range(0, lbci_pkg::MASK_COUNT - 1))];
         if ($urandom_range(0, 3) == 0) begin
            status = status | lbci_pkg::WORD_WIDTH'($urandom());
         end
      end else if (sel < 75) begin
         status = '0;
      end else begin
         status = lbci_pkg::WORD_WIDTH'($urandom());
      end
      return status;
   endfunction

   initial begin
      logic [lbci_pkg::WORD_WIDTH-1:0] mask_val;
      int unsigned                     n_items;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The slot masks keep their reset values for the directed part.
      apply_timing(16'd1, 16'd1, 16'd1);
      for (int i = 0; i < DIRECTED_N; i++) begin
         send_tick(DIRECTED[i].status, DIRECTED[i].pinned, DIRECTED[i].ind);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_until_drained();
         quiet <= (p == 5);
         for (int k = 0; k < lbci_pkg::MASK_COUNT; k++) begin
            if (p == 0 || p == PHASE_COUNT - 1) begin
               mask_val = 16'hFFFF;
            end else if (p == 1) begin
               mask_val = 16'h0000;
            end else if ($urandom_range(0, 1) == 0) begin
               mask_val = lbci_pkg::WORD_WIDTH'(1)
                          << $urandom_range(0, lbci_pkg::WORD_WIDTH - 1);
            end else begin
               mask_val = lbci_pkg::WORD_WIDTH'($urandom());
            end
            write_reg(lbci_pkg::reg_index_type'(lbci_pkg::REG_MASK_SLOT0 + k), mask_val);
         end
         // The long timer values go last, since they stall the countdown for the rest of the run.
         if (p < 2) begin
            apply_timing(16'd1, 16'd1, 16'd1);
         end else if (p == PHASE_COUNT - 1) begin
            apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
         end else begin
            apply_timing(lbci_pkg::WORD_WIDTH'($urandom_range(1, 3)),
                         lbci_pkg::WORD_WIDTH'($urandom_range(1, 40)),
                         lbci_pkg::WORD_WIDTH'($urandom_range(1, 6)));
         end
         n_items = (p == PHASE_COUNT - 1) ? 20 : 50;
         for (int j = 0; j < n_items; j++) begin
            if (p == 3 && j == 25) begin
               wait_until_drained();
            end
            send_tick(pick_status(), 1'b0, '0);
         end
      end

      wait_until_drained();
      repeat (4) @(posedge clock);
      if (pending_ind.size() != 0) begin
         $error("%0d responses never arrived", pending_ind.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ led_blink_code_status_indicator.f @@
rtl/lbci_pkg.sv
rtl/lbci_regs.sv
rtl/led_blink_code_status_indicator.sv
tb/tb_led_blink_code_status_indicator.sv
